// ----- rtl/core/vta_pkg.sv -----
// Package for the virial tensor accumulator: sizes, codes and item types.
`default_nettype none

package vta_pkg;

  localparam int NUM_SHIFTS = 32;
  localparam int SHIFT_AW   = (NUM_SHIFTS > 1) ? $clog2(NUM_SHIFTS) : 1;
  localparam int SH_IN_W    = 5;
  // wide enough for the input index, the table address and NUM_SHIFTS itself
  localparam int SH_CMP_W   = ($clog2(NUM_SHIFTS + 1) > SH_IN_W) ?
                              $clog2(NUM_SHIFTS + 1) : SH_IN_W;

  localparam int IDX_W      = 20;
  localparam int CFG_W      = 20;
  localparam int NUM_PROD   = 9;

  localparam int OUT_DEPTH  = 8;
  localparam int OUT_AW     = $clog2(OUT_DEPTH);
  localparam int CNT_W      = $clog2(OUT_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_ADD   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CFG_GRAPH_ENABLE = 2'd0,
    CFG_GRAPH_START  = 2'd1,
    CFG_GRAPH_END    = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [IDX_W-1:0]   atom_index;
    logic [SH_IN_W-1:0] shift_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic               last;
  } in_t;

  typedef struct packed {
    logic signed [63:0] vir_xx;
    logic signed [63:0] vir_xy;
    logic signed [63:0] vir_xz;
    logic signed [63:0] vir_yx;
    logic signed [63:0] vir_yy;
    logic signed [63:0] vir_yz;
    logic signed [63:0] vir_zx;
    logic signed [63:0] vir_zy;
    logic signed [63:0] vir_zz;
  } out_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } shift_vec_t;

endpackage

`default_nettype wire

// ----- rtl/core/vta_shift_mem.sv -----
// Shift vector table: one write port, one registered read port.
`default_nettype none

module vta_shift_mem (
  input  wire logic                           clk_i,
  input  wire logic                           we_i,
  input  wire logic [vta_pkg::SHIFT_AW-1:0]   waddr_i,
  input  wire vta_pkg::shift_vec_t            wdata_i,
  input  wire logic                           re_i,
  input  wire logic [vta_pkg::SHIFT_AW-1:0]   raddr_i,
  output vta_pkg::shift_vec_t                 rdata_o
);

  vta_pkg::shift_vec_t mem_q [vta_pkg::NUM_SHIFTS];
  vta_pkg::shift_vec_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/core/vta_out_fifo.sv -----
// Result FIFO between the accumulator and the output channel.
`default_nettype none

module vta_out_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire vta_pkg::out_t push_data_i,
  output logic               valid_o,
  input  wire logic          ready_i,
  output vta_pkg::out_t      data_o
);

  vta_pkg::out_t                mem_q [vta_pkg::OUT_DEPTH];
  logic [vta_pkg::OUT_AW-1:0]   wptr_q, wptr_d;
  logic [vta_pkg::OUT_AW-1:0]   rptr_q, rptr_d;
  logic [vta_pkg::CNT_W-1:0]    count_q, count_d;
  logic                         pop;

  assign valid_o = (count_q != '0);
  assign pop     = valid_o && ready_i;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = (wptr_q == vta_pkg::OUT_AW'(vta_pkg::OUT_DEPTH - 1)) ? '0 :
               wptr_q + vta_pkg::OUT_AW'(1);
    end
    if (pop) begin
      rptr_d = (rptr_q == vta_pkg::OUT_AW'(vta_pkg::OUT_DEPTH - 1)) ? '0 :
               rptr_q + vta_pkg::OUT_AW'(1);
    end
    case ({push_i, pop})
      2'b10:   count_d = count_q + vta_pkg::CNT_W'(1);
      2'b01:   count_d = count_q - vta_pkg::CNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/virial_tensor_accumulator.sv -----
// Virial tensor accumulator top level: shift lookup, products, saturating sums.
//
//   channel   direction  handshake               payload
//   in        in         in_valid_i/in_ready_o   in_data_i  (vta_pkg::in_t)
//   out       out        out_valid_o/out_ready_i out_data_o (vta_pkg::out_t)
//   cfg       in         cfg_we_i                cfg_index_i, cfg_wdata_i
//
// One item per cycle while in_ready_o is high. Stages: shift table read, position
// minus shift, nine 33x32 multiplies, saturating accumulate, tensor into the result
// FIFO. Each result passes the stage registers and the result FIFO before it is valid.
// Input ready drops only while OUT_DEPTH results are accepted but not yet taken.
// Reset clears sums, config and control; the shift table has no reset.
`default_nettype none

module virial_tensor_accumulator (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire vta_pkg::in_t               in_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output vta_pkg::out_t                   out_data_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [1:0]                 cfg_index_i,
  input  wire logic [vta_pkg::CFG_W-1:0]  cfg_wdata_i
);

  // configuration
  logic                       graph_enable_q;
  logic [vta_pkg::IDX_W-1:0]  graph_start_q;
  logic [vta_pkg::IDX_W-1:0]  graph_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      graph_enable_q <= 1'b0;
      graph_start_q  <= '0;
      graph_end_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        vta_pkg::CFG_GRAPH_ENABLE: graph_enable_q <= cfg_wdata_i[0];
        vta_pkg::CFG_GRAPH_START:  graph_start_q  <= cfg_wdata_i[vta_pkg::IDX_W-1:0];
        vta_pkg::CFG_GRAPH_END:    graph_end_q    <= cfg_wdata_i[vta_pkg::IDX_W-1:0];
        default: ;
      endcase
    end
  end

  // input decode
  logic                            in_acc;
  logic                            out_acc;
  logic [vta_pkg::SH_CMP_W-1:0]    sh_ext;
  logic [vta_pkg::SHIFT_AW-1:0]    sh_addr;
  logic                            sh_in_table;
  logic                            is_load;
  logic                            is_result;
  logic                            apply;
  logic [vta_pkg::CNT_W-1:0]       inflight_q, inflight_d;

  assign in_ready_o  = (inflight_q < vta_pkg::CNT_W'(vta_pkg::OUT_DEPTH));
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_acc     = out_valid_o && out_ready_i;
  assign sh_ext      = vta_pkg::SH_CMP_W'(in_data_i.shift_index);
  assign sh_addr     = sh_ext[vta_pkg::SHIFT_AW-1:0];
  assign sh_in_table = (sh_ext < vta_pkg::SH_CMP_W'(vta_pkg::NUM_SHIFTS));
  assign is_load     = (in_data_i.opcode == vta_pkg::OP_LOAD);
  assign is_result   = (in_data_i.opcode == vta_pkg::OP_ADD) && in_data_i.last;
  assign apply       = graph_enable_q && sh_in_table &&
                       (in_data_i.atom_index >= graph_start_q) &&
                       (in_data_i.atom_index <= graph_end_q);

  // credit for results accepted but not yet taken; keeps the FIFO from overflowing
  always_comb begin
    inflight_d = inflight_q;
    case ({in_acc && is_result, out_acc})
      2'b10:   inflight_d = inflight_q + vta_pkg::CNT_W'(1);
      2'b01:   inflight_d = inflight_q - vta_pkg::CNT_W'(1);
      default: inflight_d = inflight_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  // shift table
  vta_pkg::shift_vec_t wr_vec;
  vta_pkg::shift_vec_t rd_vec;

  assign wr_vec = '{x: in_data_i.pos_x, y: in_data_i.pos_y, z: in_data_i.pos_z};

  vta_shift_mem u_shift_mem (
    .clk_i   (clk_i),
    .we_i    (in_acc && is_load && sh_in_table),
    .waddr_i (sh_addr),
    .wdata_i (wr_vec),
    .re_i    (in_acc),
    .raddr_i (sh_addr),
    .rdata_o (rd_vec)
  );

  // stage 1: table data arrives
  logic                      s1_valid_q;
  logic [1:0]                s1_op_q;
  logic                      s1_last_q;
  logic                      s1_apply_q;
  logic signed [31:0]        s1_pos_q   [3];
  logic signed [31:0]        s1_force_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_op_q       <= in_data_i.opcode;
    s1_last_q     <= in_data_i.last;
    s1_apply_q    <= apply;
    s1_pos_q[0]   <= in_data_i.pos_x;
    s1_pos_q[1]   <= in_data_i.pos_y;
    s1_pos_q[2]   <= in_data_i.pos_z;
    s1_force_q[0] <= in_data_i.force_x;
    s1_force_q[1] <= in_data_i.force_y;
    s1_force_q[2] <= in_data_i.force_z;
  end

  logic signed [31:0] shv [3];
  logic signed [32:0] r_d [3];

  assign shv[0] = rd_vec.x;
  assign shv[1] = rd_vec.y;
  assign shv[2] = rd_vec.z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      r_d[k] = 33'(s1_pos_q[k]) - (s1_apply_q ? 33'(shv[k]) : 33'sd0);
    end
  end

  // stage 2: shifted positions
  logic                      s2_valid_q;
  logic [1:0]                s2_op_q;
  logic                      s2_last_q;
  logic signed [32:0]        s2_r_q [3];
  logic signed [31:0]        s2_f_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_op_q   <= s1_op_q;
    s2_last_q <= s1_last_q;
    s2_r_q    <= r_d;
    s2_f_q    <= s1_force_q;
  end

  logic signed [64:0] prod_d [vta_pkg::NUM_PROD];

  always_comb begin
    for (int k = 0; k < vta_pkg::NUM_PROD; k++) begin
      prod_d[k] = 65'(s2_r_q[k / 3]) * 65'(s2_f_q[k % 3]);
    end
  end

  // stage 3: products
  logic                      s3_valid_q;
  logic [1:0]                s3_op_q;
  logic                      s3_last_q;
  logic signed [64:0]        s3_prod_q [vta_pkg::NUM_PROD];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_op_q   <= s2_op_q;
    s3_last_q <= s2_last_q;
    s3_prod_q <= prod_d;
  end

  // saturating accumulate
  logic signed [63:0] sum_q [vta_pkg::NUM_PROD];
  logic signed [63:0] sum_d [vta_pkg::NUM_PROD];
  logic signed [65:0] wide  [vta_pkg::NUM_PROD];

  always_comb begin
    for (int k = 0; k < vta_pkg::NUM_PROD; k++) begin
      wide[k]  = 66'(sum_q[k]) + 66'(s3_prod_q[k]);
      sum_d[k] = sum_q[k];
      if (s3_valid_q && (s3_op_q == vta_pkg::OP_CLEAR)) begin
        sum_d[k] = '0;
      end else if (s3_valid_q && (s3_op_q == vta_pkg::OP_ADD)) begin
        if (wide[k][65:63] == 3'b000 || wide[k][65:63] == 3'b111) begin
          sum_d[k] = wide[k][63:0];
        end else if (wide[k][65]) begin
          sum_d[k] = {1'b1, 63'd0};
        end else begin
          sum_d[k] = {1'b0, {63{1'b1}}};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < vta_pkg::NUM_PROD; k++) begin
        sum_q[k] <= '0;
      end
    end else begin
      sum_q <= sum_d;
    end
  end

  // stage 4: tensor from the updated sums
  logic s4_push_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_push_q <= 1'b0;
    end else begin
      s4_push_q <= s3_valid_q && (s3_op_q == vta_pkg::OP_ADD) && s3_last_q;
    end
  end

  logic signed [63:0] half [vta_pkg::NUM_PROD];
  logic signed [63:0] vir  [vta_pkg::NUM_PROD];
  vta_pkg::out_t      push_data;

  always_comb begin
    for (int k = 0; k < vta_pkg::NUM_PROD; k++) begin
      half[k] = sum_q[k] >>> 1;
      vir[k]  = -half[k];
    end
  end

  assign push_data = vta_pkg::out_t'({vir[0], vir[1], vir[2], vir[3], vir[4],
                                      vir[5], vir[6], vir[7], vir[8]});

  vta_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s4_push_q),
    .push_data_i (push_data),
    .valid_o     (out_valid_o),
    .ready_i     (out_ready_i),
    .data_o      (out_data_o)
  );

`ifndef NO_ASSERTIONS
  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= vta_pkg::CNT_W'(vta_pkg::OUT_DEPTH))
    else $error("result credit above FIFO depth");

  a_out_has_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (inflight_q != '0))
    else $error("result shown without an item in flight");

  a_clear_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_valid_q && (s3_op_q == vta_pkg::OP_CLEAR)) |=> (sum_q[0] == '0 && sum_q[8] == '0))
    else $error("sums not zero after clear");
`endif

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// Testbench for the virial tensor accumulator: queued stimulus, predictor and tensor checks.
`timescale 1ns / 100ps

module testbench;

  localparam logic [1:0]         OP_UNUSED = 2'd3;
  localparam logic signed [31:0] MAXV      = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MINV      = 32'sh8000_0000;
  localparam logic signed [66:0] SUM_MAX   = 67'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [66:0] SUM_MIN   = 67'sh7_8000_0000_0000_0000;
  localparam int                 OUT_W     = $bits(vta_pkg::out_t);
  localparam int                 SETTLE    = 10;

  logic                      clk       = 1'b0;
  logic                      rst_n     = 1'b0;
  logic                      in_valid  = 1'b0;
  logic                      in_ready;
  vta_pkg::in_t              in_data   = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  vta_pkg::out_t             out_data;
  logic                      cfg_we    = 1'b0;
  logic [1:0]                cfg_index = '0;
  logic [vta_pkg::CFG_W-1:0] cfg_wdata = '0;

  virial_tensor_accumulator u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  // predictor state
  logic signed [63:0]        prod_sum [vta_pkg::NUM_PROD];
  logic signed [31:0]        shift_x [vta_pkg::NUM_SHIFTS];
  logic signed [31:0]        shift_y [vta_pkg::NUM_SHIFTS];
  logic signed [31:0]        shift_z [vta_pkg::NUM_SHIFTS];
  bit                        graph_on = 1'b0;
  logic [vta_pkg::IDX_W-1:0] graph_lo = '0;
  logic [vta_pkg::IDX_W-1:0] graph_hi = '0;

  // generator side view of which shift entries hold data
  bit    entry_loaded [vta_pkg::NUM_SHIFTS];

  vta_pkg::in_t   stream_q [$];
  vta_pkg::out_t  virial_q [$];
  int    queued_cnt   = 0;
  int    accepted_cnt = 0;
  int    mismatch_cnt = 0;
  bit    in_acc       = 1'b0;
  int    in_gap       = 0;
  int    in_burst     = 0;
  int    out_stall    = 0;
  int    out_burst    = 0;

  string vir_name [vta_pkg::NUM_PROD] = '{"vir_xx", "vir_xy", "vir_xz", "vir_yx", "vir_yy",
                                          "vir_yz", "vir_zx", "vir_zy", "vir_zz"};

  initial begin : clock_gen
    forever #5 clk = ~clk;
  end

  initial begin : limit
    #5_000_000;
    $display("virial_tensor_accumulator test failed");
    $finish;
  end

  initial begin
    foreach (prod_sum[k]) prod_sum[k] = '0;
    foreach (entry_loaded[k]) entry_loaded[k] = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    $display("%0t ERROR %s", $time, msg);
  endtask

  function automatic bit in_graph(input logic [vta_pkg::IDX_W-1:0] idx);
    return graph_on && idx >= graph_lo && idx <= graph_hi;
  endfunction

  function automatic void accumulate_virial(input vta_pkg::in_t it, output bit emit,
                                            output vta_pkg::out_t vir);
    logic signed [32:0] r [3];
    logic signed [31:0] f [3];
    logic signed [65:0] prod;
    logic signed [66:0] acc;
    logic signed [63:0] half;
    emit = 1'b0;
    vir  = '0;
    case (it.opcode)
      vta_pkg::OP_CLEAR: begin
        foreach (prod_sum[k]) prod_sum[k] = '0;
      end
      vta_pkg::OP_LOAD: begin
        shift_x[it.shift_index] = it.pos_x;
        shift_y[it.shift_index] = it.pos_y;
        shift_z[it.shift_index] = it.pos_z;
      end
      vta_pkg::OP_ADD: begin
        r[0] = it.pos_x;
        r[1] = it.pos_y;
        r[2] = it.pos_z;
        if (in_graph(it.atom_index)) begin
          r[0] = r[0] - shift_x[it.shift_index];
          r[1] = r[1] - shift_y[it.shift_index];
          r[2] = r[2] - shift_z[it.shift_index];
        end
        f[0] = it.force_x;
        f[1] = it.force_y;
        f[2] = it.force_z;
        for (int a = 0; a < 3; a++) begin
          for (int b = 0; b < 3; b++) begin
            prod = r[a] * f[b];
            acc  = prod_sum[a*3+b] + prod;
            if (acc > SUM_MAX) acc = SUM_MAX;
            else if (acc < SUM_MIN) acc = SUM_MIN;
            prod_sum[a*3+b] = acc[63:0];
          end
        end
        emit = it.last;
      end
      default: ;
    endcase
    if (emit) begin
      for (int k = 0; k < vta_pkg::NUM_PROD; k++) begin
        half = prod_sum[k] >>> 1;
        vir[OUT_W-1-64*k -: 64] = -half;
      end
    end
  endfunction

  function automatic vta_pkg::in_t mk(input logic [1:0] op,
                                      input logic [vta_pkg::IDX_W-1:0] idx,
                                      input logic [vta_pkg::SH_IN_W-1:0] sh,
                                      input logic signed [31:0] px,
                                      input logic signed [31:0] py,
                                      input logic signed [31:0] pz,
                                      input logic signed [31:0] fx,
                                      input logic signed [31:0] fy,
                                      input logic signed [31:0] fz,
                                      input logic lst);
    vta_pkg::in_t it;
    it.opcode      = op;
    it.atom_index  = idx;
    it.shift_index = sh;
    it.pos_x       = px;
    it.pos_y       = py;
    it.pos_z       = pz;
    it.force_x     = fx;
    it.force_y     = fy;
    it.force_z     = fz;
    it.last        = lst;
    return it;
  endfunction

  function automatic logic [vta_pkg::IDX_W-1:0] rand_idx();
    return vta_pkg::IDX_W'($urandom);
  endfunction

  function automatic logic [vta_pkg::SH_IN_W-1:0] rand_sh();
    return vta_pkg::SH_IN_W'($urandom);
  endfunction

  task automatic queue_item(input vta_pkg::in_t it);
    if (it.opcode == vta_pkg::OP_LOAD) entry_loaded[it.shift_index] = 1'b1;
    stream_q.push_back(it);
    queued_cnt++;
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // mix of extremes, full-range words and moderate values that stay unsaturated
  function automatic logic signed [31:0] rand_word();
    int v;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0: return MAXV;
          1: return MINV;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      1, 2, 3: return $urandom;
      default: begin
        v = $urandom_range(0, 2097151) - 1048576;
        return v;
      end
    endcase
  endfunction

  function automatic logic [vta_pkg::IDX_W-1:0] pick_atom();
    case ($urandom_range(0, 7))
      0: return graph_lo;
      1: return graph_hi;
      2: return graph_lo - 20'd1;
      3: return graph_hi + 20'd1;
      4, 5: begin
        if (graph_lo <= graph_hi)
          return vta_pkg::IDX_W'($urandom_range(graph_lo, graph_hi));
        return rand_idx();
      end
      default: return rand_idx();
    endcase
  endfunction

  function automatic logic [vta_pkg::SH_IN_W-1:0] pick_loaded();
    logic [vta_pkg::SH_IN_W-1:0] sh;
    do sh = vta_pkg::SH_IN_W'($urandom_range(0, vta_pkg::NUM_SHIFTS - 1));
    while (!entry_loaded[sh]);
    return sh;
  endfunction

  function automatic vta_pkg::in_t rand_atom(input logic lst);
    logic [vta_pkg::IDX_W-1:0]   idx;
    logic [vta_pkg::SH_IN_W-1:0] sh;
    idx = pick_atom();
    // an atom inside the graph must only reference a loaded entry
    sh  = in_graph(idx) ? pick_loaded() :
          vta_pkg::SH_IN_W'($urandom_range(0, vta_pkg::NUM_SHIFTS - 1));
    return mk(vta_pkg::OP_ADD, idx, sh, rand_word(), rand_word(), rand_word(),
              rand_word(), rand_word(), rand_word(), lst);
  endfunction

  task automatic queue_noise();
    case ($urandom_range(0, 3))
      0: queue_item(mk(OP_UNUSED, rand_idx(), rand_sh(), $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, 1'($urandom)));
      1: queue_item(mk(vta_pkg::OP_CLEAR, rand_idx(), rand_sh(), $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom, 1'b1));
      2: queue_item(mk(vta_pkg::OP_LOAD, rand_idx(), rand_sh(), rand_word(), rand_word(),
                       rand_word(), $urandom, $urandom, $urandom, 1'b1));
      default: queue_item(rand_atom(1'($urandom_range(0, 1))));
    endcase
  endtask

  // optional clear, up to three table loads, then a run of atoms usually closed by last
  task automatic queue_frame();
    int n;
    if ($urandom_range(0, 1))
      queue_item(mk(vta_pkg::OP_CLEAR, rand_idx(), rand_sh(), $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, 1'b0));
    n = $urandom_range(0, 3);
    repeat (n)
      queue_item(mk(vta_pkg::OP_LOAD, rand_idx(), rand_sh(), rand_word(), rand_word(),
                    rand_word(), $urandom, $urandom, $urandom, 1'b0));
    n = $urandom_range(1, 10);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) queue_noise();
      queue_item(rand_atom((i == n - 1) ? ($urandom_range(0, 9) != 0) : 1'b0));
    end
  endtask

  task automatic write_reg(input vta_pkg::cfg_idx_e idx,
                           input logic [vta_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic write_config(input bit en, input int lo, input int hi);
    write_reg(vta_pkg::CFG_GRAPH_ENABLE, vta_pkg::CFG_W'(en));
    write_reg(vta_pkg::CFG_GRAPH_START, vta_pkg::CFG_W'(lo));
    write_reg(vta_pkg::CFG_GRAPH_END, vta_pkg::CFG_W'(hi));
    graph_on = en;
    graph_lo = vta_pkg::IDX_W'(lo);
    graph_hi = vta_pkg::IDX_W'(hi);
  endtask

  task automatic drain();
    while (accepted_cnt != queued_cnt || virial_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  always @(negedge clk) begin : driver
    if (in_valid && !in_acc) begin
      // hold the item until accepted
    end else if (in_gap > 0) begin
      in_valid <= 1'b0;
      in_gap--;
    end else if (stream_q.size() > 0) begin
      in_data  <= stream_q.pop_front();
      in_valid <= 1'b1;
      if (in_burst > 0) begin
        in_burst--;
        in_gap = 0;
      end else if ($urandom_range(0, 39) == 0) begin
        in_burst = $urandom_range(20, 80);
        in_gap   = 0;
      end else begin
        in_gap = gap_len();
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin : sink
    if (out_stall > 0) begin
      out_ready <= 1'b0;
      out_stall--;
    end else begin
      out_ready <= 1'b1;
      if (out_burst > 0) out_burst--;
      else if ($urandom_range(0, 59) == 0) out_burst = $urandom_range(30, 120);
      else if ($urandom_range(0, 5) == 0) out_stall = gap_len() + 1;
    end
  end

  always @(posedge clk) begin : monitor
    bit            emit;
    vta_pkg::out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (virial_q.size() == 0) begin
          report_mismatch("tensor result with no expectation waiting");
        end else begin
          want = virial_q.pop_front();
          for (int k = 0; k < vta_pkg::NUM_PROD; k++) begin
            if (out_data[OUT_W-1-64*k -: 64] !== want[OUT_W-1-64*k -: 64])
              report_mismatch($sformatf("%s got %0d expected %0d", vir_name[k],
                              $signed(out_data[OUT_W-1-64*k -: 64]),
                              $signed(want[OUT_W-1-64*k -: 64])));
          end
        end
      end
      in_acc = in_valid && in_ready;
      if (in_acc) begin
        accumulate_virial(in_data, emit, want);
        accepted_cnt++;
        if (emit) virial_q.push_back(want);
      end
    end
  end

  initial begin : stimulus
    int lo;
    int hi;
    int first;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // graph off: extremes, saturation both ways, ignored last, unused opcode
    write_config(1'b0, 0, 0);
    queue_item(mk(vta_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    queue_item(mk(vta_pkg::OP_LOAD, 0, 0, MAXV, MINV, 0, 0, 0, 0, 1'b0));
    queue_item(mk(vta_pkg::OP_LOAD, 0, 31, MINV, MAXV, -1, 0, 0, 0, 1'b0));
    queue_item(mk(vta_pkg::OP_ADD, 20'hFFFFF, 31, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, 1'b1));
    queue_item(mk(vta_pkg::OP_ADD, 0, 0, MINV, MINV, MINV, MINV, MINV, MINV, 1'b0));
    queue_item(mk(vta_pkg::OP_ADD, 0, 0, MINV, MINV, MINV, MINV, MINV, MINV, 1'b1));
    queue_item(mk(vta_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
    queue_item(mk(vta_pkg::OP_ADD, 1, 1, MINV, MINV, MINV, MAXV, MAXV, MAXV, 1'b0));
    queue_item(mk(vta_pkg::OP_ADD, 1, 1, MINV, MINV, MINV, MAXV, MAXV, MAXV, 1'b0));
    queue_item(mk(vta_pkg::OP_ADD, 1, 1, MINV, MINV, MINV, MAXV, MAXV, MAXV, 1'b1));
    queue_item(mk(OP_UNUSED, 20'hFFFFF, 31, -1, -1, -1, -1, -1, -1, 1'b1));
    queue_item(mk(vta_pkg::OP_LOAD, 0, 5, 32'sh0001_8000, -32'sh0002_0000, 32'sh0000_4000,
                  0, 0, 0, 1'b1));
    queue_item(mk(vta_pkg::OP_ADD, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
    queue_item(mk(vta_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    // odd negative sums check the floor in the halving
    queue_item(mk(vta_pkg::OP_ADD, 7, 3, 32'sh0003_0000, -1, 1, -32'sh0005_0000, 7, MINV,
                  1'b1));
    drain();

    // whole index space in the graph: shifted positions reach 33 bits
    write_config(1'b1, 0, 20'hFFFFF);
    queue_item(mk(vta_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    queue_item(mk(vta_pkg::OP_ADD, 0, 31, MAXV, MINV, 0, MINV, MAXV, -1, 1'b1));
    queue_item(mk(vta_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    queue_item(mk(vta_pkg::OP_ADD, 20'hFFFFF, 0, MINV, MAXV, 1, MINV, MINV, MAXV, 1'b1));
    queue_item(mk(vta_pkg::OP_ADD, 12345, 5, 32'sh0000_8000, 32'sh0001_0000,
                  -32'sh0000_2000, 32'sh0002_0000, -32'sh0001_0000, 32'sh0000_0100, 1'b1));
    drain();

    // empty range: start above end, nothing is shifted
    write_config(1'b1, 20'hFFFFF, 0);
    queue_item(mk(vta_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    queue_item(mk(vta_pkg::OP_ADD, 0, 31, MAXV, MINV, 0, MINV, MAXV, -1, 1'b1));
    queue_item(mk(vta_pkg::OP_ADD, 20'hFFFFF, 0, MINV, MAXV, 1, MINV, MINV, MAXV, 1'b1));
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: write_config(1'b1, 0, 20'hFFFFF);
        1: begin
          lo = $urandom_range(0, 20'hFFFFF);
          hi = lo + $urandom_range(0, 2000);
          if (hi > 20'hFFFFF) hi = 20'hFFFFF;
          write_config(1'b1, lo, hi);
        end
        2: write_config(1'b0, $urandom_range(0, 20'hFFFFF), $urandom_range(0, 20'hFFFFF));
        3: begin
          lo = $urandom_range(0, 20'hFFFFF);
          write_config(1'b1, lo, lo);
        end
        4: begin
          lo = $urandom_range(1, 20'hFFFFF);
          write_config(1'b1, lo, $urandom_range(0, lo - 1));
        end
        5: write_config(1'b1, 20'hFFFFF, 20'hFFFFF);
        6: write_config(1'b1, 0, 0);
        default: begin
          lo = $urandom_range(0, 20'hFFFFF);
          hi = $urandom_range(0, 20'hFFFFF);
          if (lo > hi) write_config(1'b1, hi, lo);
          else write_config(1'b1, lo, hi);
        end
      endcase
      first = queued_cnt;
      while (queued_cnt - first < 100) queue_frame();
      drain();
    end

    if (mismatch_cnt == 0 && virial_q.size() == 0) begin
      $display("virial_tensor_accumulator test passed");
    end else begin
      $display("virial_tensor_accumulator test failed");
    end
    $finish;
  end

endmodule
